>>> hw/rtl/mft_record_fixup_core_macros.svh
// Assertion helpers shared by the fixup RTL.
`ifndef MFT_RECORD_FIXUP_CORE_MACROS_SVH
`define MFT_RECORD_FIXUP_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MFT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mft_record_fixup: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mft_record_fixup: assertion failed");

`endif

>>> hw/rtl/mft_pkg.sv
`default_nettype none

package mft_pkg;

    // Record signature "FILE" as two little-endian words
    localparam logic [15:0] SIG_LO = 16'h4946;
    localparam logic [15:0] SIG_HI = 16'h454C;

    localparam logic [12:0] SECTOR_BYTES_RESET = 13'd512;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SIG     = 2'd1,
        ST_MISMATCH   = 2'd2,
        ST_BAD_LAYOUT = 2'd3
    } t_status;

    typedef struct packed {
        logic [15:0] data;
        logic        last;
    } t_word;

    // log2 of the highest power of two in the register, clamped to 8..12
    function automatic logic [3:0] sector_shift(input logic [12:0] bytes);
        logic [3:0] s;
        begin
            s = 4'd8;
            if (bytes >= 13'd512)  s = 4'd9;
            if (bytes >= 13'd1024) s = 4'd10;
            if (bytes >= 13'd2048) s = 4'd11;
            if (bytes >= 13'd4096) s = 4'd12;
            return s;
        end
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mft_entry_store.sv
`default_nettype none

module mft_entry_store #(
    parameter int MAX_FIXUPS = 16,
    localparam int IW = $clog2(MAX_FIXUPS)
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [IW-1:0] i_wr_idx,
    input  wire logic [15:0]   i_wr_data,
    input  wire logic [IW-1:0] i_rd_idx,
    output logic      [15:0]   o_rd_data
);

    // entry 0 is the sequence value, kept in the controller
    logic [15:0] r_entry [MAX_FIXUPS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_entry[i_wr_idx] <= i_wr_data;
        end
    end

    assign o_rd_data = r_entry[i_rd_idx];

endmodule

`default_nettype wire

>>> hw/rtl/mft_in_stage.sv
`default_nettype none

module mft_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire mft_pkg::t_word i_word,
    output logic               o_stall,
    input  wire logic          i_take,
    output logic               o_valid,
    output mft_pkg::t_word     o_word
);

    logic           r_valid;
    mft_pkg::t_word r_word;
    logic           load;

    assign o_stall = r_valid && !i_take;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

>>> hw/rtl/mft_fixup_ctl.sv
`default_nettype none

`include "mft_record_fixup_core_macros.svh"

module mft_fixup_ctl #(
    parameter int MAX_FIXUPS = 16,
    parameter int MAX_RECORD_WORDS = 2048,
    localparam int IW = $clog2(MAX_FIXUPS),
    localparam int PW = $clog2(MAX_RECORD_WORDS + 1)
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire mft_pkg::t_word i_word,
    input  wire logic [3:0]     i_shift,
    input  wire logic [15:0]    i_rd_data,
    output logic                o_wr_en,
    output logic [IW-1:0]       o_wr_idx,
    output logic [15:0]         o_wr_data,
    output logic [IW-1:0]       o_rd_idx,
    output logic [15:0]         o_fixed_word,
    output mft_pkg::t_status    o_status
);

    logic [PW-1:0]    r_pos, n_pos;
    logic [15:0]      r_off, n_off;
    logic [15:0]      r_cnt, n_cnt;
    logic [15:0]      r_seq, n_seq;
    mft_pkg::t_status r_err, n_err;

    logic [15:0] p16, p1_16, half_mask, k16, cap_idx16, entry_eff;
    logic [17:0] lay_sum, lay_lim;
    logic        in_range, cap_wr, sec_end;

    assign in_range  = r_pos < PW'(MAX_RECORD_WORDS);
    assign p16       = 16'(r_pos);
    assign p1_16     = p16 + 16'd1;
    // a sector spans 2^(shift-1) words
    assign half_mask = (16'd1 << (i_shift - 4'd1)) - 16'd1;
    assign k16       = p1_16 >> (i_shift - 4'd1);
    assign cap_idx16 = p16 - {1'b0, r_off[15:1]};
    assign lay_sum   = {2'b00, r_off} + {1'b0, i_word.data, 1'b0};
    assign lay_lim   = (18'd1 << i_shift) - 18'd2;
    assign o_rd_idx  = k16[IW-1:0];

    always_comb begin
        n_pos        = r_pos;
        n_off        = r_off;
        n_cnt        = r_cnt;
        n_seq        = r_seq;
        n_err        = r_err;
        cap_wr       = 1'b0;
        sec_end      = 1'b0;
        entry_eff    = i_rd_data;
        o_fixed_word = i_word.data;
        o_status     = mft_pkg::ST_OK;
        if (in_range) begin
            if (r_pos == PW'(0)) begin
                n_seq = i_word.data;
            end else if (r_pos == PW'(1)) begin
                if (r_err == mft_pkg::ST_OK &&
                    (r_seq != mft_pkg::SIG_LO || i_word.data != mft_pkg::SIG_HI)) begin
                    n_err = mft_pkg::ST_NO_SIG;
                end
                n_seq = 16'd0;
            end else if (r_pos == PW'(2)) begin
                n_off = i_word.data;
            end else if (r_pos == PW'(3)) begin
                n_cnt = i_word.data;
                if (r_err == mft_pkg::ST_OK) begin
                    if (i_word.data > 16'(MAX_FIXUPS)) begin
                        n_err = mft_pkg::ST_BAD_LAYOUT;
                    end else if (i_word.data >= 16'd2 &&
                                 (r_off[0] || r_off < 16'd8 || lay_sum > lay_lim)) begin
                        n_err = mft_pkg::ST_BAD_LAYOUT;
                    end
                end
            end else if (r_err == mft_pkg::ST_OK && r_cnt >= 16'd2 &&
                         p16 >= {1'b0, r_off[15:1]}) begin
                // offset is even and past the header here
                if (cap_idx16 < r_cnt && cap_idx16 < 16'(MAX_FIXUPS)) begin
                    if (cap_idx16 == 16'd0) begin
                        n_seq = i_word.data;
                    end else begin
                        cap_wr = 1'b1;
                    end
                end
            end

            // forward a capture of the same entry in this word
            if (cap_wr && cap_idx16[IW-1:0] == k16[IW-1:0]) begin
                entry_eff = i_word.data;
            end

            sec_end = (p1_16 & half_mask) == 16'd0;
            if (sec_end && n_err == mft_pkg::ST_OK && k16 < n_cnt &&
                k16 < 16'(MAX_FIXUPS)) begin
                if (i_word.data != n_seq) begin
                    n_err = mft_pkg::ST_MISMATCH;
                end else begin
                    o_fixed_word = entry_eff;
                end
            end
            n_pos = r_pos + PW'(1);
        end

        if (i_word.last) begin
            if (r_pos == PW'(0)) begin
                o_status = mft_pkg::ST_NO_SIG;
            end else if (r_pos < PW'(3) && n_err == mft_pkg::ST_OK) begin
                o_status = mft_pkg::ST_BAD_LAYOUT;
            end else begin
                o_status = n_err;
            end
            n_pos = '0;
            n_off = 16'd0;
            n_cnt = 16'd0;
            n_seq = 16'd0;
            n_err = mft_pkg::ST_OK;
        end
    end

    assign o_wr_en   = i_en && cap_wr;
    assign o_wr_idx  = cap_idx16[IW-1:0];
    assign o_wr_data = i_word.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_off <= 16'd0;
            r_cnt <= 16'd0;
            r_seq <= 16'd0;
            r_err <= mft_pkg::ST_OK;
        end else if (i_en) begin
            r_pos <= n_pos;
            r_off <= n_off;
            r_cnt <= n_cnt;
            r_seq <= n_seq;
            r_err <= n_err;
        end
    end

    `MFT_ASSERT_IMPL(a_pos_bound, i_clk, i_rst_n, 1'b1, r_pos <= PW'(MAX_RECORD_WORDS))
    `MFT_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, i_en && i_word.last, r_pos == '0 && r_err == mft_pkg::ST_OK)
    `MFT_ASSERT_IMPL(a_fix_at_trailer, i_clk, i_rst_n, i_en && o_fixed_word != i_word.data, sec_end && r_err == mft_pkg::ST_OK)

endmodule

`default_nettype wire

>>> hw/rtl/mft_record_fixup_core.sv
// Path: a word accepted into the input register goes through one combinational
// pass into the result register, which drives the outputs.
// Throughput: one word per cycle; the input stalls only while both registers
// hold a word and the output is stalled.
// Reset (i_rst_n, synchronous, active low): empties both registers, clears the
// record state and sets sector_bytes to 512; the fixup array is not cleared.
`default_nettype none

`include "mft_record_fixup_core_macros.svh"

module mft_record_fixup_core #(
    parameter int MAX_FIXUPS = 16,
    parameter int MAX_RECORD_WORDS = 2048
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // record words in
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [15:0] i_data_word,
    input  wire logic        i_last_word,
    // fixed words out
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_fixed_word,
    output logic             o_end_of_record,
    output logic [1:0]       o_record_status,
    // sector size register
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [12:0] i_cfg_sector_bytes
);

    localparam int IW = $clog2(MAX_FIXUPS);

    // Configuration: sector size in bytes, only its highest set bit counts.
    logic [12:0] r_sector_bytes;
    logic [3:0]  sec_shift;

    assign o_cfg_ready = 1'b1;
    assign sec_shift   = mft_pkg::sector_shift(r_sector_bytes);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector_bytes <= mft_pkg::SECTOR_BYTES_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sector_bytes <= i_cfg_sector_bytes;
        end
    end

    // Input register. It moves on whenever the result register can take
    // a word; with a result waiting downstream it holds one more word and
    // then stalls the input.
    mft_pkg::t_word in_word, s1_word;
    logic           s1_valid, out_free, adv;

    assign in_word.data = i_data_word;
    assign in_word.last = i_last_word;
    assign out_free     = !o_out_valid || !i_out_stall;
    assign adv          = s1_valid && out_free;

    mft_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_word  (in_word),
        .o_stall (o_in_stall),
        .i_take  (out_free),
        .o_valid (s1_valid),
        .o_word  (s1_word)
    );

    // Record walk: header decode, array capture and trailer check/replace.
    logic             wr_en;
    logic [IW-1:0]    wr_idx, rd_idx;
    logic [15:0]      wr_data, rd_data, fixed_word;
    mft_pkg::t_status status;

    mft_fixup_ctl #(
        .MAX_FIXUPS       (MAX_FIXUPS),
        .MAX_RECORD_WORDS (MAX_RECORD_WORDS)
    ) u_fixup_ctl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (adv),
        .i_word       (s1_word),
        .i_shift      (sec_shift),
        .i_rd_data    (rd_data),
        .o_wr_en      (wr_en),
        .o_wr_idx     (wr_idx),
        .o_wr_data    (wr_data),
        .o_rd_idx     (rd_idx),
        .o_fixed_word (fixed_word),
        .o_status     (status)
    );

    // Update sequence array entries 1..count-1.
    mft_entry_store #(
        .MAX_FIXUPS (MAX_FIXUPS)
    ) u_entry_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_idx  (wr_idx),
        .i_wr_data (wr_data),
        .i_rd_idx  (rd_idx),
        .o_rd_data (rd_data)
    );

    // Result register.
    logic             r_out_valid;
    logic [15:0]      r_fixed_word;
    logic             r_end_of_record;
    mft_pkg::t_status r_status;
    logic             mid_record_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fixed_word    <= fixed_word;
            r_end_of_record <= s1_word.last;
            r_status        <= status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_fixed_word    = r_fixed_word;
    assign o_end_of_record = r_end_of_record;
    assign o_record_status = r_status;

    assign mid_record_out  = o_out_valid && !o_end_of_record;

    `MFT_ASSERT_IMPL(a_stall_needs_word, i_clk, i_rst_n, o_in_stall, s1_valid && o_out_valid)
    `MFT_ASSERT_NEXT(a_adv_gives_result, i_clk, i_rst_n, adv, o_out_valid)
    `MFT_ASSERT_IMPL(a_status_at_end, i_clk, i_rst_n, mid_record_out, r_status == mft_pkg::ST_OK)

endmodule

`default_nettype wire
